>>> design/dht_pkg.sv
// Shared types and constants for the Huffman-table segment parser.
// No dependencies; imported by every module of the block.
package dht_pkg;

    // Number of code lengths in a table header
    localparam int CODE_LENGTHS = 16;
    localparam int IDX_W        = $clog2(CODE_LENGTHS);
    localparam int LEN_W        = IDX_W + 1;

    localparam logic [3:0] NIB_MASK  = 4'b1111;
    localparam logic [3:0] CLASS_MAX = 4'd1;
    localparam logic [3:0] IDENT_MAX = 4'd3;
    localparam logic [15:0] LEN_BYTES = 16'd2;

    // One result beat leaving the control logic
    typedef struct packed {
        logic             valid;
        logic [7:0]       symbol;
        logic [LEN_W-1:0] code_length;
        logic             table_class;
        logic [1:0]       table_id;
        logic             last_of_table;
        logic             last_of_segment;
        logic             bad_table;
        logic             truncated;
    } t_dht_result;

    // Outcome of the code-length search
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_dht_pick;

endpackage

>>> design/dht_len_pick.sv
// Priority encoder: lowest code length at or above a start index with a nonzero count.
// Depends on dht_pkg.
module dht_len_pick
    import dht_pkg::*;
(
    input  logic [CODE_LENGTHS-1:0] i_nonzero,
    input  logic [LEN_W-1:0]        i_start,
    output t_dht_pick               o_pick
);

    logic [CODE_LENGTHS-1:0] w_mask;

    // Keep only lengths at or above the start index
    always_comb begin
        for (int i = 0; i < CODE_LENGTHS; i++) begin
            w_mask[i] = i_nonzero[i] && (LEN_W'(i) >= i_start);
        end
    end

    // Scan from the top so the lowest set bit wins
    always_comb begin
        o_pick = '0;
        for (int i = CODE_LENGTHS - 1; i >= 0; i--) begin
            if (w_mask[i]) begin
                o_pick.found = 1'b1;
                o_pick.idx   = IDX_W'(i);
            end
        end
    end

endmodule

>>> design/dht_ctrl.sv
// Segment control: length tracking, table header capture, count store and symbol labeling.
// Depends on dht_pkg and dht_len_pick.
module dht_ctrl
    import dht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_segment_start,
    output t_dht_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_TCTH,
        PH_COUNTS,
        PH_SYMBOLS
    } t_phase;

    t_phase            r_phase,    n_phase;
    logic [15:0]       r_seg_len,  n_seg_len;
    logic [15:0]       r_consumed, n_consumed;
    logic [IDX_W-1:0]  r_cnt_idx,  n_cnt_idx;
    logic [LEN_W-1:0]  r_cur_len,  n_cur_len;
    logic [7:0]        r_lil,      n_lil;
    logic [11:0]       r_lit,      n_lit;
    logic [3:0]        r_class,    n_class;
    logic [3:0]        r_ident,    n_ident;

    // Count store and its nonzero flags, written in header order
    logic [7:0]              r_counts [CODE_LENGTHS];
    logic [CODE_LENGTHS-1:0] r_nz;
    logic                    w_cnt_we;

    logic [CODE_LENGTHS-1:0] w_sel_onehot;
    logic [CODE_LENGTHS-1:0] w_pick_nz;
    logic [LEN_W-1:0]        w_pick_start;
    t_dht_pick               w_pick;
    logic [7:0]              w_pick_cnt;
    logic [15:0]             w_cons_inc;
    logic                    w_seg_end;
    logic                    w_last_tab;
    logic [11:0]             w_lit_dec;
    logic [7:0]              w_lil_dec;

    assign w_sel_onehot = CODE_LENGTHS'(1) << r_cnt_idx;
    assign w_cnt_we     = i_accept && !i_segment_start && (r_phase == PH_COUNTS);

    // Merge the count arriving now into the flags seen by the search
    always_comb begin
        if (r_phase == PH_COUNTS) begin
            w_pick_nz    = (r_nz & ~w_sel_onehot)
                         | ((i_data_byte != 8'd0) ? w_sel_onehot : '0);
            w_pick_start = '0;
        end else begin
            w_pick_nz    = r_nz;
            w_pick_start = r_cur_len;
        end
    end

    dht_len_pick u_pick (
        .i_nonzero (w_pick_nz),
        .i_start   (w_pick_start),
        .o_pick    (w_pick)
    );

    // Count of the picked length, forwarding the byte being written
    always_comb begin
        if (r_phase == PH_COUNTS && w_pick.idx == r_cnt_idx) begin
            w_pick_cnt = i_data_byte;
        end else begin
            w_pick_cnt = r_counts[w_pick.idx];
        end
    end

    assign w_cons_inc = 16'(r_consumed + 16'd1);
    assign w_seg_end  = w_cons_inc >= r_seg_len;
    assign w_lit_dec  = 12'(r_lit - 12'd1);
    assign w_lil_dec  = 8'(r_lil - 8'd1);

    // Next state and result for the accepted byte
    always_comb begin
        n_phase    = r_phase;
        n_seg_len  = r_seg_len;
        n_consumed = r_consumed;
        n_cnt_idx  = r_cnt_idx;
        n_cur_len  = r_cur_len;
        n_lil      = r_lil;
        n_lit      = r_lit;
        n_class    = r_class;
        n_ident    = r_ident;
        w_last_tab = 1'b0;
        o_result   = '0;

        if (i_segment_start) begin
            n_seg_len  = {i_data_byte, 8'd0};
            n_consumed = 16'd1;
            n_phase    = PH_LEN_LO;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_LEN_LO: begin
                    n_seg_len  = r_seg_len | {8'd0, i_data_byte};
                    n_consumed = LEN_BYTES;
                    n_phase    = (LEN_BYTES >= n_seg_len) ? PH_IDLE : PH_TCTH;
                end
                PH_TCTH: begin
                    n_consumed = w_cons_inc;
                    n_class    = (i_data_byte[7:4]) & NIB_MASK;
                    n_ident    = i_data_byte[3:0] & NIB_MASK;
                    n_cnt_idx  = '0;
                    n_lit      = '0;
                    if (w_seg_end) begin
                        n_phase                  = PH_IDLE;
                        o_result.valid           = 1'b1;
                        o_result.last_of_segment = 1'b1;
                        o_result.truncated       = 1'b1;
                    end else begin
                        n_phase = PH_COUNTS;
                    end
                end
                PH_COUNTS: begin
                    n_consumed = w_cons_inc;
                    n_lit      = 12'(r_lit + 12'(i_data_byte));
                    n_cnt_idx  = IDX_W'(r_cnt_idx + IDX_W'(1));
                    if (r_cnt_idx != IDX_W'(CODE_LENGTHS - 1)) begin
                        if (w_seg_end) begin
                            n_phase                  = PH_IDLE;
                            o_result.valid           = 1'b1;
                            o_result.last_of_segment = 1'b1;
                            o_result.truncated       = 1'b1;
                        end
                    end else if (n_lit == 12'd0) begin
                        n_phase = w_seg_end ? PH_IDLE : PH_TCTH;
                    end else if (w_seg_end) begin
                        n_phase                  = PH_IDLE;
                        o_result.valid           = 1'b1;
                        o_result.last_of_segment = 1'b1;
                        o_result.truncated       = 1'b1;
                    end else begin
                        n_cur_len = LEN_W'(w_pick.idx) + LEN_W'(1);
                        n_lil     = w_pick.found ? w_pick_cnt : 8'd0;
                        n_phase   = PH_SYMBOLS;
                    end
                end
                PH_SYMBOLS: begin
                    n_consumed = w_cons_inc;
                    n_lit      = w_lit_dec;
                    n_lil      = w_lil_dec;
                    w_last_tab = (w_lit_dec == 12'd0);
                    // Move on to the next nonempty length when this one runs out
                    if (!w_last_tab && w_lil_dec == 8'd0) begin
                        if (w_pick.found) begin
                            n_cur_len = LEN_W'(w_pick.idx) + LEN_W'(1);
                            n_lil     = w_pick_cnt;
                        end else begin
                            n_cur_len  = LEN_W'(CODE_LENGTHS + 1);
                            n_lil      = 8'd0;
                            w_last_tab = 1'b1;
                        end
                    end
                    o_result.valid       = 1'b1;
                    o_result.symbol      = i_data_byte;
                    o_result.code_length = r_cur_len;
                    if (w_last_tab) begin
                        n_lit                    = '0;
                        n_phase                  = w_seg_end ? PH_IDLE : PH_TCTH;
                        o_result.last_of_table   = 1'b1;
                        o_result.last_of_segment = w_seg_end;
                    end else if (w_seg_end) begin
                        n_phase                  = PH_IDLE;
                        o_result.last_of_segment = 1'b1;
                        o_result.truncated       = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_result.table_class = n_class[0];
        o_result.table_id    = n_ident[1:0];
        o_result.bad_table   = (n_class > CLASS_MAX) || (n_ident > IDENT_MAX);
        o_result.valid       = o_result.valid && i_accept;
    end

    // Hold state; advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_seg_len  <= '0;
            r_consumed <= '0;
            r_cnt_idx  <= '0;
            r_cur_len  <= '0;
            r_lil      <= '0;
            r_lit      <= '0;
            r_class    <= '0;
            r_ident    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_seg_len  <= n_seg_len;
            r_consumed <= n_consumed;
            r_cnt_idx  <= n_cnt_idx;
            r_cur_len  <= n_cur_len;
            r_lil      <= n_lil;
            r_lit      <= n_lit;
            r_class    <= n_class;
            r_ident    <= n_ident;
        end
    end

    // Store each count byte and its nonzero flag
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_counts[r_cnt_idx] <= i_data_byte;
            r_nz[r_cnt_idx]     <= (i_data_byte != 8'd0);
        end
    end

    // Symbols are only due while the table still owes some
    a_sym_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SYMBOLS) |-> (r_lit != 12'd0))
        else $error("symbol phase with no symbols left in table");

    // The current code length stays a real length during symbols
    a_sym_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SYMBOLS) |->
            (r_cur_len != '0 && r_cur_len <= LEN_W'(CODE_LENGTHS)))
        else $error("code length out of range in symbol phase");

    // A start byte always leads to the low length byte
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_segment_start) |=> (r_phase == PH_LEN_LO))
        else $error("segment start did not enter length phase");

endmodule

>>> design/jpeg_huffman_table_segment_parser.sv
// Top level of the Huffman-table segment parser: handshakes and the result register.
// Depends on dht_pkg and dht_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one segment byte per beat,
//   i_segment_start high on the first (high) length byte of a segment.
//   Output channel (o_out_valid / i_out_ready) carries one labeled symbol per
//   beat, with class, id, code length, end-of-table and end-of-segment flags,
//   plus bad_table and truncated status.
//   Each input byte gives zero or one result. A result appears in the output
//   register the cycle after its byte is accepted.
//   Throughput is one byte per cycle unless the output stalls: all work per
//   byte is one pass through the control logic, with the length search done
//   by a 16-way priority encoder. The output register holds a result until it
//   is taken; a new byte is accepted whenever that register is empty or is
//   being drained this cycle, so a stalled receiver stops the input only while
//   its result waits. Reset returns the parser to idle and empties the output
//   register; bytes seen while idle without a start flag are dropped.
module jpeg_huffman_table_segment_parser
    import dht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_segment_start,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_symbol,
    output logic [LEN_W-1:0] o_code_length,
    output logic             o_table_class,
    output logic [1:0]       o_table_id,
    output logic             o_last_of_table,
    output logic             o_last_of_segment,
    output logic             o_bad_table,
    output logic             o_truncated
);

    logic        w_accept;
    t_dht_result w_result;
    t_dht_result r_out;
    logic        r_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    dht_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_segment_start (i_segment_start),
        .o_result        (w_result)
    );

    // Load a new result, or drop the current one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid && o_in_ready) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_symbol          = r_out.symbol;
    assign o_code_length     = r_out.code_length;
    assign o_table_class     = r_out.table_class;
    assign o_table_id        = r_out.table_id;
    assign o_last_of_table   = r_out.last_of_table;
    assign o_last_of_segment = r_out.last_of_segment;
    assign o_bad_table       = r_out.bad_table;
    assign o_truncated       = r_out.truncated;

    // A complete symbol carries a real code length
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_truncated) |->
            (o_code_length != '0 && o_code_length <= LEN_W'(CODE_LENGTHS)))
        else $error("untruncated result with bad code length");

    // Truncation always closes the segment and never the table
    a_trunc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> (o_last_of_segment && !o_last_of_table))
        else $error("truncated result with inconsistent end flags");

    // A result that ends the segment without a table end must be truncated
    a_seg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_segment && !o_last_of_table) |-> o_truncated)
        else $error("segment ended mid-table without truncation");

endmodule

>>> sim/tb.sv
// Self-checking testbench for jpeg_huffman_table_segment_parser: drives segment bytes,
// predicts labeled symbols with its own parser model, and checks every output beat.
// Depends on dht_pkg and the parser RTL.
module tb;
    import dht_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int TARGET_BEATS = 600;
    localparam int TAIL_CYCLES  = 8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_TABLE_HDR,
        PH_COUNTS,
        PH_SYMBOLS
    } t_parse_phase;

    // One input beat; drain_first holds it back until every symbol has come out
    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         drain_first;
    } t_seg_beat;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_segment_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [7:0]       o_symbol;
    logic [LEN_W-1:0] o_code_length;
    logic             o_table_class;
    logic [1:0]       o_table_id;
    logic             o_last_of_table;
    logic             o_last_of_segment;
    logic             o_bad_table;
    logic             o_truncated;

    t_seg_beat   seg_bytes_q[$];
    t_dht_result expected_symbols_q[$];
    int          symbols_pending = 0;
    int          stall_cycles = 0;
    int          fail_cnt = 0;
    int          beats_sent = 0;
    int          stim_total = 0;
    int          stray_cnt = 0;

    // Parser state mirrored by the predictor
    t_parse_phase parse_ph;
    logic [15:0]  seg_len_r;
    logic [15:0]  consumed_r;
    logic [7:0]   lcount [CODE_LENGTHS];
    logic [4:0]   count_idx;
    logic [4:0]   cur_len;
    logic [7:0]   left_len;
    logic [11:0]  left_tab;
    logic [3:0]   cls_nib;
    logic [3:0]   id_nib;

    jpeg_huffman_table_segment_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_segment_start   (i_segment_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_symbol          (o_symbol),
        .o_code_length     (o_code_length),
        .o_table_class     (o_table_class),
        .o_table_id        (o_table_id),
        .o_last_of_table   (o_last_of_table),
        .o_last_of_segment (o_last_of_segment),
        .o_bad_table       (o_bad_table),
        .o_truncated       (o_truncated)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void dht_model_reset();
        parse_ph   = PH_IDLE;
        seg_len_r  = '0;
        consumed_r = '0;
        count_idx  = '0;
        cur_len    = '0;
        left_len   = '0;
        left_tab   = '0;
        cls_nib    = '0;
        id_nib     = '0;
        for (int i = 0; i < CODE_LENGTHS; i++) begin
            lcount[i] = '0;
        end
    endfunction

    function automatic t_dht_result dht_emit(logic [7:0] sym, logic [4:0] len, logic lot,
                                             logic los, logic trunc);
        t_dht_result r;
        r.valid           = 1'b1;
        r.symbol          = sym;
        r.code_length     = len;
        r.table_class     = cls_nib[0];
        r.table_id        = id_nib[1:0];
        r.last_of_table   = lot;
        r.last_of_segment = los;
        r.bad_table       = (cls_nib > CLASS_MAX) || (id_nib > IDENT_MAX);
        r.truncated       = trunc;
        return r;
    endfunction

    // Index of the first code length at or after 'from' that still has symbols
    function automatic int next_used_length(int from);
        for (int i = from; i < CODE_LENGTHS; i++) begin
            if (lcount[i] != 8'h00) return i;
        end
        return CODE_LENGTHS;
    endfunction

    // Advance the parser model by one byte; valid set when a symbol comes out
    function automatic t_dht_result dht_predict_byte(logic [7:0] b, logic start);
        t_dht_result none;
        logic        seg_end;
        logic        last_tab;
        logic [4:0]  len;
        int          k;
        none = '0;
        if (start) begin
            seg_len_r  = {b, 8'h00};
            consumed_r = 16'd1;
            parse_ph   = PH_LEN_LO;
            return none;
        end
        case (parse_ph)
            PH_IDLE: begin
                return none;
            end
            PH_LEN_LO: begin
                seg_len_r[7:0] = b;
                consumed_r     = LEN_BYTES;
                if (consumed_r >= seg_len_r) parse_ph = PH_IDLE;
                else parse_ph = PH_TABLE_HDR;
                return none;
            end
            default: ;
        endcase

        consumed_r = consumed_r + 16'd1;
        seg_end    = consumed_r >= seg_len_r;

        // Class/identifier byte opens a table
        if (parse_ph == PH_TABLE_HDR) begin
            cls_nib   = b[7:4];
            id_nib    = b[3:0];
            count_idx = '0;
            left_tab  = '0;
            if (seg_end) begin
                parse_ph = PH_IDLE;
                return dht_emit(8'h00, 5'd0, 1'b0, 1'b1, 1'b1);
            end
            parse_ph = PH_COUNTS;
            return none;
        end

        // Per-length counts
        if (parse_ph == PH_COUNTS) begin
            lcount[count_idx[3:0]] = b;
            left_tab  = left_tab + 12'(b);
            count_idx = count_idx + 5'd1;
            if (count_idx < CODE_LENGTHS) begin
                if (seg_end) begin
                    parse_ph = PH_IDLE;
                    return dht_emit(8'h00, 5'd0, 1'b0, 1'b1, 1'b1);
                end
                return none;
            end
            if (left_tab == 12'd0) begin
                if (seg_end) parse_ph = PH_IDLE;
                else parse_ph = PH_TABLE_HDR;
                return none;
            end
            if (seg_end) begin
                parse_ph = PH_IDLE;
                return dht_emit(8'h00, 5'd0, 1'b0, 1'b1, 1'b1);
            end
            k        = next_used_length(0);
            cur_len  = 5'(k + 1);
            left_len = (k < CODE_LENGTHS) ? lcount[k] : 8'h00;
            parse_ph = PH_SYMBOLS;
            return none;
        end

        // Symbol bytes: label with the current length, then step to the next used one
        len      = cur_len;
        left_tab = left_tab - 12'd1;
        left_len = left_len - 8'd1;
        last_tab = (left_tab == 12'd0);
        if (!last_tab && left_len == 8'h00) begin
            k        = next_used_length(int'(cur_len));
            cur_len  = 5'(k + 1);
            left_len = (k < CODE_LENGTHS) ? lcount[k] : 8'h00;
            if (k >= CODE_LENGTHS) last_tab = 1'b1;
        end
        if (last_tab) begin
            left_tab = '0;
            if (seg_end) parse_ph = PH_IDLE;
            else parse_ph = PH_TABLE_HDR;
            return dht_emit(b, len, 1'b1, seg_end, 1'b0);
        end
        if (seg_end) begin
            parse_ph = PH_IDLE;
            return dht_emit(b, len, 1'b0, 1'b1, 1'b1);
        end
        return dht_emit(b, len, 1'b0, 1'b0, 1'b0);
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic push_seg_beat(logic [7:0] data, logic start, bit drain_first = 1'b0);
        t_seg_beat beat;
        beat.data        = data;
        beat.start       = start;
        beat.drain_first = drain_first;
        seg_bytes_q.insert(seg_bytes_q.size(), beat);
    endtask

    task automatic push_seg_len(logic [15:0] seg_len, bit drain_first = 1'b0);
        push_seg_beat(seg_len[15:8], 1'b1, drain_first);
        push_seg_beat(seg_len[7:0], 1'b0);
    endtask

    // Bytes without a start flag; dropped when the parser is idle
    task automatic add_stray_bytes(int n);
        for (int i = 0; i < n; i++) begin
            push_seg_beat(8'($urandom_range(0, 255)), 1'b0);
            stray_cnt++;
        end
    endtask

    // One segment of 1..3 random tables, mostly well formed
    task automatic add_random_segment(bit drain_first);
        logic [7:0]  body[$];
        logic [7:0]  cnt;
        logic [15:0] seg_len;
        int          n_tab;
        int          n_sym;
        int          send_n;
        int          mode;
        int          style;
        int          pick;
        int          t;
        int          i;
        n_tab = $urandom_range(1, 3);
        for (t = 0; t < n_tab; t++) begin
            if ($urandom_range(0, 7) == 0) begin
                body.insert(body.size(), 8'($urandom_range(0, 255)));
            end else begin
                body.insert(body.size(), {3'b000, 1'($urandom_range(0, 1)), 2'b00,
                                          2'($urandom_range(0, 3))});
            end
            style = $urandom_range(0, 9);
            pick  = $urandom_range(0, CODE_LENGTHS - 1);
            n_sym = 0;
            for (i = 0; i < CODE_LENGTHS; i++) begin
                if (style == 0) begin
                    cnt = 8'h00;
                end else if (style == 1) begin
                    if (i != pick) cnt = 8'h00;
                    else if ($urandom_range(0, 39) == 0) cnt = 8'hFF;
                    else cnt = 8'($urandom_range(1, 20));
                end else if ($urandom_range(0, 4) == 0) begin
                    cnt = 8'($urandom_range(1, 3));
                end else begin
                    cnt = 8'h00;
                end
                body.insert(body.size(), cnt);
                n_sym += cnt;
            end
            for (i = 0; i < n_sym; i++) begin
                body.insert(body.size(), 8'($urandom_range(0, 255)));
            end
        end

        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                // length cuts the segment short somewhere inside
                seg_len = 16'($urandom_range(3, body.size() + 1));
                send_n  = seg_len - 2;
            end
            1: begin
                // cut off by the next start flag
                seg_len = 16'(body.size() + 2);
                send_n  = $urandom_range(0, body.size() - 1);
            end
            2: begin
                // arbitrary length, a few bytes, then the next start
                seg_len = 16'($urandom_range(0, 65535));
                send_n  = $urandom_range(0, 20);
                if (send_n > body.size()) send_n = body.size();
            end
            default: begin
                seg_len = 16'(body.size() + 2);
                send_n  = body.size();
            end
        endcase

        push_seg_len(seg_len, drain_first);
        for (i = 0; i < send_n; i++) begin
            push_seg_beat(body[i], 1'b0);
        end
        if ($urandom_range(0, 7) == 0) add_stray_bytes($urandom_range(1, 3));
    endtask

    task automatic build_directed();
        // stray byte while idle
        push_seg_beat(8'hA5, 1'b0);
        // lengths too short to hold a table
        push_seg_len(16'h0000);
        push_seg_len(16'h0002);
        // ends on the class/identifier byte
        push_seg_len(16'h0003);
        push_seg_beat(8'h13, 1'b0);
        // ends among the counts, bad class nibble
        push_seg_len(16'h0006);
        push_seg_beat(8'h2F, 1'b0);
        push_seg_beat(8'h01, 1'b0);
        push_seg_beat(8'h00, 1'b0);
        push_seg_beat(8'h00, 1'b0);
        // aborted by a new start flag
        push_seg_len(16'h0100);
        push_seg_beat(8'h01, 1'b0);
        push_seg_beat(8'h04, 1'b0);
        // full table: one symbol of length 1, two of length 16
        push_seg_len(16'd22);
        push_seg_beat(8'h13, 1'b0);
        for (int i = 0; i < CODE_LENGTHS; i++) begin
            if (i == 0) push_seg_beat(8'h01, 1'b0);
            else if (i == CODE_LENGTHS - 1) push_seg_beat(8'h02, 1'b0);
            else push_seg_beat(8'h00, 1'b0);
        end
        push_seg_beat(8'h00, 1'b0);
        push_seg_beat(8'hFF, 1'b0);
        push_seg_beat(8'h5A, 1'b0);
    endtask

    // ---------------------------------------------------------------- driver

    // Present bytes from the queue; hold valid and payload until the beat is taken
    always @(posedge i_clk) begin : drive_bytes
        t_seg_beat nxt;
        int        src_gap_pct;
        int        snk_gap_pct;
        bit        took;
        bit        held_back;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) beats_sent++;
            if (beats_sent < stim_total / 3) begin
                src_gap_pct = 20;
                snk_gap_pct = 67;
            end else if (beats_sent < 2 * stim_total / 3) begin
                src_gap_pct = 67;
                snk_gap_pct = 20;
            end else begin
                src_gap_pct = 0;
                snk_gap_pct = 0;
            end
            i_out_ready <= ($urandom_range(0, 99) >= snk_gap_pct);

            held_back = seg_bytes_q.size() != 0 && seg_bytes_q[0].drain_first &&
                        (i_in_valid || symbols_pending != 0 || o_out_valid);
            if (i_in_valid && !took) begin
                // hold the current beat
            end else if (seg_bytes_q.size() != 0 && !held_back &&
                         $urandom_range(0, 99) >= src_gap_pct) begin
                nxt = seg_bytes_q.pop_front();
                i_in_valid      <= 1'b1;
                i_data_byte     <= nxt.data;
                i_segment_start <= nxt.start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Predict on every accepted byte, compare every accepted symbol beat
    always @(posedge i_clk) begin : check_symbols
        t_dht_result predicted;
        t_dht_result want;
        bit          moved;
        if (!i_rst_n) begin
            dht_model_reset();
            symbols_pending <= 0;
            stall_cycles    <= 0;
        end else begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                moved     = 1'b1;
                predicted = dht_predict_byte(i_data_byte, i_segment_start);
                if (predicted.valid) begin
                    expected_symbols_q.insert(expected_symbols_q.size(), predicted);
                end
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_symbols_q.size() == 0) begin
                    $error("unexpected symbol beat: symbol %0d", o_symbol);
                    fail_cnt++;
                end else begin
                    want = expected_symbols_q.pop_front();
                    check_field("symbol", want.symbol, o_symbol);
                    check_field("code_length", want.code_length, o_code_length);
                    check_field("table_class", want.table_class, o_table_class);
                    check_field("table_id", want.table_id, o_table_id);
                    check_field("last_of_table", want.last_of_table, o_last_of_table);
                    check_field("last_of_segment", want.last_of_segment, o_last_of_segment);
                    check_field("bad_table", want.bad_table, o_bad_table);
                    check_field("truncated", want.truncated, o_truncated);
                end
            end
            symbols_pending <= expected_symbols_q.size();

            // Watchdog: no beat on either side for too long
            if (moved) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run_test
        int seg_no;
        build_directed();
        seg_no = 0;
        while (seg_bytes_q.size() - stray_cnt < TARGET_BEATS) begin
            add_random_segment(seg_no % 6 == 2);
            seg_no++;
        end
        stim_total = seg_bytes_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last byte to go in, then for its symbols to drain
        while (seg_bytes_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (symbols_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_symbols_q.size() != 0) begin
            $error("%0d expected symbols never arrived", expected_symbols_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/dht_pkg.sv
design/dht_len_pick.sv
design/dht_ctrl.sv
design/jpeg_huffman_table_segment_parser.sv
sim/tb.sv
